// ----- rtl/particle_force_integrate_step_macros.svh -----
// Assertion macros used by the particle step RTL.
`ifndef PARTICLE_FORCE_INTEGRATE_STEP_MACROS_SVH
`define PARTICLE_FORCE_INTEGRATE_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define PFIS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pfis assertion failed");
`define PFIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfis assertion failed");
`else
`define PFIS_ASSERT(lbl, clk, rst, prop)
`define PFIS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/pfis_pkg.sv -----
// Types and constants of the particle step block.
`timescale 1ns / 1ps
package pfis_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUID_DENSITY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_COEFFICIENT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_MARGIN    = 3'd4;

   localparam logic [16:0] TIME_STEP_RESET        = 17'd1092;
   localparam logic [30:0] GRAVITY_RESET          = 31'd642908;
   localparam logic [30:0] FLUID_DENSITY_RESET    = 31'd80282;
   localparam logic [30:0] DRAG_COEFFICIENT_RESET = 31'd30802;
   localparam logic [16:0] GROUND_MARGIN_RESET    = 17'd66;

   localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] FX_MIN = 32'h8000_0000;

   // quotient bits of the buoyancy divider
   localparam int DIV_QW = 31;

   typedef logic [31:0] fx_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        body_radius;
      logic [16:0]        restitution;
      logic [30:0]        body_mass;
      logic [30:0]        body_volume;
      logic [30:0]        frontal_area;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               ground_hit;
   } rsp_type;

   typedef struct packed {
      fx_type [2:0] pos;
      fx_type [2:0] vel;
      logic [30:0]  radius;
      logic [16:0]  rest;
      logic [30:0]  mass;
      logic [30:0]  volume;
      logic [30:0]  area;
      fx_type       k;
   } ctx_type;

   typedef struct packed {
      logic [DIV_QW-1:0] rem;
      logic [DIV_QW-1:0] quo;
      logic [DIV_QW-1:0] nlo;
      logic              ovf;
   } div_type;

endpackage

// ----- rtl/particle_force_integrate_step.sv -----
// Particle step: gravity, buoyancy, quadratic drag, Euler move and ground bounce.
//
// One particle record per cycle while no result is held, fully pipelined.
// The depth is set by the buoyancy quotient, a restoring divider with one
// quotient bit per stage over 31 stages, with every multiply in a stage of
// its own and its saturation in the next. When a result is held at the
// output, the whole pipeline holds and req_ready drops.
`timescale 1ns / 1ps
module particle_force_integrate_step #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pfis_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pfis_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [pfis_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfis_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pfis_pkg::*;
   `include "particle_force_integrate_step_macros.svh"

   localparam int NW     = 31 + FRAC_BITS;
   localparam int S_DIV  = 5;
   localparam int S_BMUL = S_DIV + DIV_QW + 1;
   localparam int S_BUOY = S_BMUL + 1;
   localparam int S_MM   = S_BUOY + 1;
   localparam int S_MMS  = S_MM + 1;
   localparam int S_MK   = S_MMS + 1;
   localparam int S_MKS  = S_MK + 1;
   localparam int S_MD   = S_MKS + 1;
   localparam int S_DRAG = S_MD + 1;
   localparam int S_PMUL = S_DRAG + 1;
   localparam int S_PSUM = S_PMUL + 1;
   localparam int NS     = S_PSUM + 1;

   function automatic fx_type mag32(input fx_type v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic fx_type fx_sat(input logic [63:0] prod, input logic neg);
      logic [63:0] m;
      m = prod >> FRAC_BITS;
      if (neg) begin
         if (m >= 64'h8000_0000) return FX_MIN;
         return ~m[31:0] + 32'd1;
      end
      if (m > 64'h7FFF_FFFF) return FX_MAX;
      return m[31:0];
   endfunction

   function automatic logic [32:0] ext33(input fx_type v);
      return {v[31], v};
   endfunction

   function automatic fx_type sat33(input logic [32:0] s);
      if (s[32] != s[31]) return s[32] ? FX_MIN : FX_MAX;
      return s[31:0];
   endfunction

   logic [16:0] time_step_ff;
   logic [30:0] gravity_ff;
   logic [30:0] fluid_density_ff;
   logic [30:0] drag_coefficient_ff;
   logic [16:0] ground_margin_ff;

   logic [NS:1] vld_ff;
   logic        en;
   ctx_type     ctx_ff [1:NS-1];
   ctx_type     ctx_in [1:NS-1];
   div_type     div_ff [0:DIV_QW];
   div_type     div_in [0:DIV_QW];

   logic [63:0] prod_rg_ff, prod_gdt_ff, prod_rc_ff;
   fx_type      rg_ff, gdt_ff, rc_ff;
   logic [63:0] prod_rgv_ff, prod_k_ff;
   logic [30:0] m2_ff;
   logic [63:0] prod_b_ff;
   logic [63:0] prod_mm_ff [3];
   fx_type      mm_ff [3];
   logic [63:0] prod_mk_ff [3];
   fx_type      mk_ff [3];
   logic [63:0] prod_md_ff [3];
   logic [63:0] prod_pv_ff [3];
   logic [2:0]  neg_pv_ff;
   logic [63:0] prod_vr_ff;
   logic        neg_vr_ff;
   fx_type      pn_ff [3];
   fx_type      vr_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   assign en        = !vld_ff[NS] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NS];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff        <= TIME_STEP_RESET;
         gravity_ff          <= GRAVITY_RESET;
         fluid_density_ff    <= FLUID_DENSITY_RESET;
         drag_coefficient_ff <= DRAG_COEFFICIENT_RESET;
         ground_margin_ff    <= GROUND_MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP:        time_step_ff        <= csr_wdata[16:0];
            CSR_GRAVITY:          gravity_ff          <= csr_wdata[30:0];
            CSR_FLUID_DENSITY:    fluid_density_ff    <= csr_wdata[30:0];
            CSR_DRAG_COEFFICIENT: drag_coefficient_ff <= csr_wdata[30:0];
            CSR_GROUND_MARGIN:    ground_margin_ff    <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-1:1], req_valid};
      end
   end

   // context carried along the pipe, updated where a stage changes it
   always_comb begin
      fx_type      v;
      fx_type      d;
      ctx_in[1].pos    = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
      ctx_in[1].vel    = {req_data.vel_z, req_data.vel_y, req_data.vel_x};
      ctx_in[1].radius = req_data.body_radius;
      ctx_in[1].rest   = req_data.restitution;
      ctx_in[1].mass   = req_data.body_mass;
      ctx_in[1].volume = req_data.body_volume;
      ctx_in[1].area   = req_data.frontal_area;
      ctx_in[1].k      = '0;
      for (int s = 2; s < NS; s++) begin
         ctx_in[s] = ctx_ff[s-1];
      end
      ctx_in[3].vel[1] = sat33(ext33(ctx_ff[2].vel[1]) - ext33(gdt_ff));
      ctx_in[4].k = fx_sat(prod_k_ff, 1'b0);
      ctx_in[S_BUOY].vel[1] = sat33(ext33(ctx_ff[S_BUOY-1].vel[1])
                                    + ext33(fx_sat(prod_b_ff, 1'b0)));
      for (int a = 0; a < 3; a++) begin
         v = ctx_ff[S_DRAG-1].vel[a];
         d = fx_sat(prod_md_ff[a], 1'b0);
         if (v == '0) begin
            ctx_in[S_DRAG].vel[a] = v;
         end else if (v[31]) begin
            ctx_in[S_DRAG].vel[a] = sat33(ext33(v) + ext33(d));
         end else begin
            ctx_in[S_DRAG].vel[a] = sat33(ext33(v) - ext33(d));
         end
      end
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      logic [NW-1:0] n_full;
      logic [31:0]   r;
      logic          ge;
      n_full = {m2_ff, {FRAC_BITS{1'b0}}};
      div_in[0].rem = DIV_QW'(n_full >> DIV_QW);
      div_in[0].nlo = n_full[DIV_QW-1:0];
      div_in[0].quo = '0;
      div_in[0].ovf = DIV_QW'(n_full >> DIV_QW) >= ctx_ff[S_DIV-1].mass;
      for (int j = 0; j < DIV_QW; j++) begin
         r  = {div_ff[j].rem, div_ff[j].nlo[DIV_QW-1-j]};
         ge = r >= {1'b0, ctx_ff[S_DIV+j].mass};
         div_in[j+1] = div_ff[j];
         div_in[j+1].rem = ge ? DIV_QW'(r - {1'b0, ctx_ff[S_DIV+j].mass}) : r[DIV_QW-1:0];
         div_in[j+1].quo[DIV_QW-1-j] = ge;
      end
   end

   always_comb begin
      logic [33:0] diff;
      logic [31:0] rm;
      logic        hit;
      diff = {{2{pn_ff[1][31]}}, pn_ff[1]} - {3'b000, ctx_ff[NS-1].radius};
      hit  = $signed(diff) < $signed({17'd0, ground_margin_ff});
      rm   = {1'b0, ctx_ff[NS-1].radius} + {15'd0, ground_margin_ff};
      rsp_data_in.new_pos_x  = pn_ff[0];
      rsp_data_in.new_pos_z  = pn_ff[2];
      rsp_data_in.new_vel_x  = ctx_ff[NS-1].vel[0];
      rsp_data_in.new_vel_z  = ctx_ff[NS-1].vel[2];
      rsp_data_in.new_pos_y  = hit ? (rm[31] ? FX_MAX : rm) : pn_ff[1];
      rsp_data_in.new_vel_y  = hit ? vr_ff : ctx_ff[NS-1].vel[1];
      rsp_data_in.ground_hit = hit;
   end

   always_ff @(posedge clock) begin
      logic [30:0] qsel;
      fx_type      vd;
      if (en) begin
         for (int s = 1; s < NS; s++) begin
            ctx_ff[s] <= ctx_in[s];
         end
         for (int j = 0; j <= DIV_QW; j++) begin
            div_ff[j] <= div_in[j];
         end
         prod_rg_ff  <= 64'(fluid_density_ff) * 64'(gravity_ff);
         prod_gdt_ff <= 64'(gravity_ff) * 64'(time_step_ff);
         prod_rc_ff  <= 64'(fluid_density_ff >> 1) * 64'(drag_coefficient_ff);
         rg_ff  <= fx_sat(prod_rg_ff, 1'b0);
         gdt_ff <= fx_sat(prod_gdt_ff, 1'b0);
         rc_ff  <= fx_sat(prod_rc_ff, 1'b0);
         prod_rgv_ff <= 64'(rg_ff) * 64'(ctx_ff[2].volume);
         prod_k_ff   <= 64'(rc_ff) * 64'(ctx_ff[2].area);
         m2_ff <= 31'(fx_sat(prod_rgv_ff, 1'b0) & FX_MAX);
         if (ctx_ff[S_BMUL-1].mass == '0) begin
            qsel = '0;
         end else if (div_ff[DIV_QW].ovf) begin
            qsel = FX_MAX[30:0];
         end else begin
            qsel = div_ff[DIV_QW].quo;
         end
         prod_b_ff <= 64'(qsel) * 64'(time_step_ff);
         for (int a = 0; a < 3; a++) begin
            prod_mm_ff[a] <= 64'(mag32(ctx_ff[S_MM-1].vel[a]))
                             * 64'(mag32(ctx_ff[S_MM-1].vel[a]));
            mm_ff[a]      <= fx_sat(prod_mm_ff[a], 1'b0);
            prod_mk_ff[a] <= 64'(mm_ff[a]) * 64'(ctx_ff[S_MK-1].k);
            mk_ff[a]      <= fx_sat(prod_mk_ff[a], 1'b0);
            prod_md_ff[a] <= 64'(mk_ff[a]) * 64'(time_step_ff);
            vd = ctx_ff[S_PMUL-1].vel[a];
            prod_pv_ff[a] <= 64'(mag32(vd)) * 64'(time_step_ff);
            neg_pv_ff[a]  <= vd[31];
            pn_ff[a] <= sat33(ext33(ctx_ff[S_PSUM-1].pos[a])
                              + ext33(fx_sat(prod_pv_ff[a], neg_pv_ff[a])));
         end
         prod_vr_ff <= 64'(mag32(ctx_ff[S_PMUL-1].vel[1]))
                       * 64'(ctx_ff[S_PMUL-1].rest);
         neg_vr_ff  <= ctx_ff[S_PMUL-1].vel[1][31];
         vr_ff <= sat33(33'd0 - ext33(fx_sat(prod_vr_ff, neg_vr_ff)));
         rsp_data_ff <= rsp_data_in;
      end
   end

   `PFIS_ASSERT(a_bounce_above_ground, clock, reset, rsp_valid && rsp_data.ground_hit |-> !rsp_data.new_pos_y[31])
   `PFIS_ASSERT(a_div_rem_bound, clock, reset, vld_ff[S_DIV+DIV_QW] && !div_ff[DIV_QW].ovf && (ctx_ff[S_DIV+DIV_QW].mass != '0) |-> (div_ff[DIV_QW].rem < ctx_ff[S_DIV+DIV_QW].mass))
   `PFIS_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !en, $stable(vld_ff))

endmodule
